### sv/delta_list_sleep_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta list sleep queue
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_SLEEP_QUEUE_UNIT_ASSERT_SVH
`define DELTA_LIST_SLEEP_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DLSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dlsq_pkg.sv
// ----------------------------------------------------------------------------
// dlsq_pkg
// Shared constants and types of the delta list sleep queue.
// ----------------------------------------------------------------------------
package dlsq_pkg;

  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned TimeBitsDefault = 32;

  localparam int unsigned IdBits    = 8;
  localparam int unsigned TicksBits = 32;

  localparam logic MODE_SLEEP = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_WAKE = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_WCMP,
    S_SHRD,
    S_SHWR,
    S_INS,
    S_TCMP,
    S_TLOOK,
    S_TNEXT
  } state_e;

endpackage

### sv/delta_list_sleep_queue_unit.sv
// Sleep insert: the walk reads entries in order (S_WALK, S_WCMP) until it reaches the tail or
// a larger delta, shifts the later entries up (S_SHRD, S_SHWR) and writes the new entry (S_INS),
// which registers the acknowledge; zero time or a full queue is acknowledged the next cycle.
// Tick: a wake run gives one result per expired entry, the last one marked with last_o.
// Reset (rst_ni low, asynchronous) empties the queue at once; no clearing pass is needed.
// One memory access per cycle, one request in work at a time; results cannot be held off.
module delta_list_sleep_queue_unit #(
  parameter int unsigned DEPTH     = dlsq_pkg::DepthDefault,
  parameter int unsigned TIME_BITS = dlsq_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode_i,
  input  logic [dlsq_pkg::IdBits-1:0]    thread_id_i,
  input  logic [dlsq_pkg::TicksBits-1:0] sleep_ticks_i,
  output logic                           result_valid_o,
  output logic                           kind_o,
  output logic [dlsq_pkg::IdBits-1:0]    woken_id_o,
  output logic [1:0]                     status_o,
  output logic                           last_o
);
  import dlsq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic                 wr_en;
  logic [PW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_delta;
  logic [IdBits-1:0]    wr_id;
  logic                 rd_en;
  logic [PW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd_delta;
  logic [IdBits-1:0]    rd_id;

  dlsq_ctrl #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .thread_id_i    (thread_id_i),
    .sleep_ticks_i  (sleep_ticks_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .woken_id_o     (woken_id_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_delta_o     (wr_delta),
    .wr_id_o        (wr_id),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_delta_i     (rd_delta),
    .rd_id_i        (rd_id)
  );

  dlsq_mem #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_delta_i (wr_delta),
    .wr_id_i    (wr_id),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_delta_o (rd_delta),
    .rd_id_o    (rd_id)
  );

endmodule

### sv/dlsq_mem.sv
// ----------------------------------------------------------------------------
// dlsq_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dlsq_mem #(
  parameter int unsigned DEPTH     = dlsq_pkg::DepthDefault,
  parameter int unsigned TIME_BITS = dlsq_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic [TIME_BITS-1:0]          wr_delta_i,
  input  logic [dlsq_pkg::IdBits-1:0]   wr_id_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic [TIME_BITS-1:0]          rd_delta_o,
  output logic [dlsq_pkg::IdBits-1:0]   rd_id_o
);
  import dlsq_pkg::*;

  logic [TIME_BITS-1:0] delta_mem [DEPTH];
  logic [IdBits-1:0]    id_mem    [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      delta_mem[wr_addr_i] <= wr_delta_i;
      id_mem[wr_addr_i]    <= wr_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_delta_o <= delta_mem[rd_addr_i];
      rd_id_o    <= id_mem[rd_addr_i];
    end
  end

endmodule

### sv/dlsq_ctrl.sv
// ----------------------------------------------------------------------------
// dlsq_ctrl
// Sequencer of the sleep queue: walks, shifts and pops the entry memory,
// kept as a ring with a head pointer, and registers the results.
// ----------------------------------------------------------------------------
`include "delta_list_sleep_queue_unit_assert.svh"

module dlsq_ctrl #(
  parameter int unsigned DEPTH     = dlsq_pkg::DepthDefault,
  parameter int unsigned TIME_BITS = dlsq_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode_i,
  input  logic [dlsq_pkg::IdBits-1:0]    thread_id_i,
  input  logic [dlsq_pkg::TicksBits-1:0] sleep_ticks_i,
  output logic                           result_valid_o,
  output logic                           kind_o,
  output logic [dlsq_pkg::IdBits-1:0]    woken_id_o,
  output logic [1:0]                     status_o,
  output logic                           last_o,
  output logic                           wr_en_o,
  output logic [$clog2(DEPTH)-1:0]       wr_addr_o,
  output logic [TIME_BITS-1:0]           wr_delta_o,
  output logic [dlsq_pkg::IdBits-1:0]    wr_id_o,
  output logic                           rd_en_o,
  output logic [$clog2(DEPTH)-1:0]       rd_addr_o,
  input  logic [TIME_BITS-1:0]           rd_delta_i,
  input  logic [dlsq_pkg::IdBits-1:0]    rd_id_i
);
  import dlsq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [PW-1:0]        head_q, head_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [TIME_BITS-1:0] t_q, t_d;
  logic [IdBits-1:0]    id_q, id_d;
  logic [IdBits-1:0]    pend_q, pend_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q, out_kind_d;
  logic [IdBits-1:0]    out_id_q, out_id_d;
  logic [1:0]           out_status_q, out_status_d;
  logic                 out_last_q, out_last_d;

  logic [TIME_BITS-1:0] t_in;
  logic [PW-1:0]        head_inc;

  // map a position in the list onto the ring
  function automatic logic [PW-1:0] ring_addr(input logic [PW-1:0] head,
                                              input logic [CW-1:0] lg);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(lg);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign t_in     = TIME_BITS'(sleep_ticks_i);
  assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign busy     = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    t_q          <= t_d;
    id_q         <= id_d;
    pend_q       <= pend_d;
    out_kind_q   <= out_kind_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    t_d          = t_q;
    id_d         = id_q;
    pend_d       = pend_q;
    out_valid_d  = 1'b0;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = ring_addr(head_q, pos_q);
    wr_delta_o   = rd_delta_i;
    wr_id_o      = rd_id_i;
    rd_en_o      = 1'b0;
    rd_addr_o    = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (mode_i == MODE_SLEEP) begin
            if (t_in == '0 || count_q == CW'(DEPTH)) begin
              // answer at once, queue untouched
              out_valid_d  = 1'b1;
              out_kind_d   = KIND_ACK;
              out_id_d     = thread_id_i;
              out_status_d = (t_in == '0) ? ST_ZERO : ST_FULL;
              out_last_d   = 1'b1;
            end else begin
              t_d     = t_in;
              id_d    = thread_id_i;
              pos_d   = '0;
              state_d = S_WALK;
            end
          end else if (count_q != '0) begin
            rd_en_o   = 1'b1;
            rd_addr_o = head_q;
            state_d   = S_TCMP;
          end
        end
      end
      S_WALK: begin
        if (pos_q == count_q) begin
          idx_d   = count_q;
          state_d = S_SHRD;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = ring_addr(head_q, pos_q);
          state_d   = S_WCMP;
        end
      end
      S_WCMP: begin
        if (t_q < rd_delta_i) begin
          // successor keeps only what remains after the new entry
          wr_en_o    = 1'b1;
          wr_addr_o  = ring_addr(head_q, pos_q);
          wr_delta_o = rd_delta_i - t_q;
          wr_id_o    = rd_id_i;
          idx_d      = count_q;
          state_d    = S_SHRD;
        end else begin
          t_d     = t_q - rd_delta_i;
          pos_d   = pos_q + CW'(1);
          state_d = S_WALK;
        end
      end
      S_SHRD: begin
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = ring_addr(head_q, idx_q - CW'(1));
          state_d   = S_SHWR;
        end
      end
      S_SHWR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = ring_addr(head_q, idx_q);
        idx_d     = idx_q - CW'(1);
        state_d   = S_SHRD;
      end
      S_INS: begin
        wr_en_o      = 1'b1;
        wr_addr_o    = ring_addr(head_q, pos_q);
        wr_delta_o   = t_q;
        wr_id_o      = id_q;
        count_d      = count_q + CW'(1);
        out_valid_d  = 1'b1;
        out_kind_d   = KIND_ACK;
        out_id_d     = id_q;
        out_status_d = ST_OK;
        out_last_d   = 1'b1;
        state_d      = S_IDLE;
      end
      S_TCMP: begin
        if (rd_delta_i == '0) begin
          state_d = S_IDLE;
        end else if (rd_delta_i != TIME_BITS'(1)) begin
          wr_en_o    = 1'b1;
          wr_addr_o  = head_q;
          wr_delta_o = rd_delta_i - TIME_BITS'(1);
          state_d    = S_IDLE;
        end else begin
          // head expires: pop it and hold its id until the next is known
          pend_d  = rd_id_i;
          head_d  = head_inc;
          count_d = count_q - CW'(1);
          state_d = S_TLOOK;
        end
      end
      S_TLOOK: begin
        if (count_q == '0) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_WAKE;
          out_id_d     = pend_q;
          out_status_d = ST_OK;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = head_q;
          state_d   = S_TNEXT;
        end
      end
      S_TNEXT: begin
        out_valid_d  = 1'b1;
        out_kind_d   = KIND_WAKE;
        out_id_d     = pend_q;
        out_status_d = ST_OK;
        if (rd_delta_i == '0) begin
          out_last_d = 1'b0;
          pend_d     = rd_id_i;
          head_d     = head_inc;
          count_d    = count_q - CW'(1);
          state_d    = S_TLOOK;
        end else begin
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign result_valid_o = out_valid_q;
  assign kind_o         = out_kind_q;
  assign woken_id_o     = out_id_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  `DLSQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count beyond depth")
  `DLSQ_ASSERT_NEXT(a_insert_busy, start && !busy && mode_i == MODE_SLEEP && t_in != '0 && count_q != CW'(DEPTH), busy && count_q == $past(count_q), "insert did not start")
  `DLSQ_ASSERT_NEXT(a_insert_ack, state_q == S_INS, result_valid_o && last_o && kind_o == KIND_ACK && count_q == $past(count_q) + CW'(1), "insert without ack")
  `DLSQ_ASSERT_IMPL(a_wake_ok, result_valid_o && kind_o == KIND_WAKE, status_o == ST_OK, "wake with bad status")
  `DLSQ_ASSERT_IMPL(a_tick_nonempty, state_q == S_TCMP, count_q != '0, "tick read on empty queue")

endmodule
